// File: rtl/mm_pkg.sv
`default_nettype none

package mm_pkg;

    // Field and register widths fixed by the item formats
    localparam int ELEM_W   = 32;
    localparam int DIM_W    = 4;
    localparam int IDX_W    = 3;
    localparam int STAT_W   = 2;
    localparam int NEED_W   = 2 * DIM_W;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int OUT_W    = ELEM_W + 2 * IDX_W + STAT_W;
    localparam int FRAC_W   = 16;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [1:0] REG_COLS_FIRST  = 2'd1;
    localparam logic [1:0] REG_ROWS_SECOND = 2'd2;
    localparam logic [1:0] REG_COLS_SECOND = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_SAT      = 2'd2;

    // Operand tag that travels with the store read data into the MAC
    typedef struct packed {
        logic valid;
        logic last;
    } mac_ctl_t;

    // Finished dot product from the MAC
    typedef struct packed {
        logic              done;
        logic              sat;
        logic [ELEM_W-1:0] value;
    } mac_res_t;

    // Clamp a dimension register into 1..max_dim
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > max_dim)
            r = max_dim;
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mm_ram.sv
`default_nettype none

module mm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [AW-1:0]           waddr,
    input  wire logic [WIDTH-1:0]        wdata,
    input  wire logic [AW-1:0]           raddr,
    output logic      [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/mm_mac.sv
`default_nettype none

module mm_mac #(
    parameter int ACC_W = 68
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mm_pkg::mac_ctl_t               ctl,
    input  wire logic [mm_pkg::ELEM_W-1:0]      a,
    input  wire logic [mm_pkg::ELEM_W-1:0]      b,
    output mm_pkg::mac_res_t                    res
);

    localparam int TOP = mm_pkg::FRAC_W + mm_pkg::ELEM_W - 1;

    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic                             p_valid_reg;
    logic                             p_last_reg;

    logic signed [ACC_W-1:0]          acc_reg;
    logic signed [ACC_W-1:0]          acc_next;
    logic                             acc_first_reg;
    logic                             acc_done_reg;

    logic signed [ACC_W-1:0]          rnd;
    logic                             rnd_sat;
    logic [mm_pkg::ELEM_W-1:0]        rnd_value;

    logic                             done_reg;
    logic                             sat_reg;
    logic [mm_pkg::ELEM_W-1:0]        value_reg;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
        end
        else
        begin
            p_valid_reg <= ctl.valid;
            p_last_reg  <= ctl.valid & ctl.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(a) * $signed(b);
    end

    // Accumulate stage: restart the sum on the first term of each element
    always_comb
    begin
        acc_next = (acc_first_reg ? ACC_W'(0) : acc_reg)
                 + {{(ACC_W - mm_pkg::PROD_W){prod_reg[mm_pkg::PROD_W-1]}}, prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_first_reg <= 1'b1;
            acc_done_reg  <= 1'b0;
        end
        else
        begin
            acc_done_reg <= p_valid_reg & p_last_reg;
            if (p_valid_reg)
            begin
                acc_first_reg <= p_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // Round to nearest (ties up), drop the fraction, clamp to 32 bits
    always_comb
    begin
        rnd     = acc_reg + ACC_W'(1 << (mm_pkg::FRAC_W - 1));
        rnd_sat = !((&rnd[ACC_W-1:TOP]) || (~|rnd[ACC_W-1:TOP]));
        if (!rnd_sat)
            rnd_value = rnd[TOP:mm_pkg::FRAC_W];
        else if (rnd[ACC_W-1])
            rnd_value = {1'b1, {(mm_pkg::ELEM_W - 1){1'b0}}};
        else
            rnd_value = {1'b0, {(mm_pkg::ELEM_W - 1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= acc_done_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_done_reg)
        begin
            sat_reg   <= rnd_sat;
            value_reg <= rnd_value;
        end
    end

    assign res.done  = done_reg;
    assign res.sat   = sat_reg;
    assign res.value = value_reg;

endmodule

`default_nettype wire

// File: rtl/matrix_multiply.sv
`default_nettype none

// Channel   Dir  Payload                                         Handshake
// apb       in   psel/penable/pwrite/paddr/pwdata -> prdata       pready tied high
// s_axis    in   tuser: kind; tdata: element                      s_tvalid/s_tready
// m_axis    out  tdata: product, row_index, col_index, status;    m_tvalid/m_tready
//                tlast: last
//
// Loading takes one input item per cycle while s_tready is high. The item that completes both
// stores starts a run of rows_first * cols_second product elements, each summed over cols_first
// terms on the single multiply-accumulate unit fed by the two store read ports.
// s_tready is low for the whole run; a stalled m_tready holds the run at the emit step.
// A size mismatch gives one item and no run. Reset clears counts and state; stores are not cleared.
module matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mm_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [mm_pkg::DATA_W-1:0]     pwdata,
    output logic      [mm_pkg::DATA_W-1:0]     prdata,
    output logic                               pready,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mm_pkg::ELEM_W-1:0]     s_tdata,   // [31:0] element
    input  wire logic                          s_tuser,   // [0] kind

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [mm_pkg::OUT_W-1:0]      m_tdata,   // [31:0] product, [34:32] row_index,
                                                          // [37:35] col_index, [39:38] status
    output logic                               m_tlast
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ACC_W = mm_pkg::PROD_W + $clog2(MAX_DIM) + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_ERR   = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;

    logic [mm_pkg::DIM_W-1:0]       rows_first_reg, cols_first_reg;
    logic [mm_pkg::DIM_W-1:0]       rows_second_reg, cols_second_reg;
    logic [mm_pkg::DIM_W-1:0]       ra, ca, rb, cb;
    logic [mm_pkg::NEED_W-1:0]      need_a, need_b;

    logic [CW-1:0]                  a_cnt_reg, a_cnt_next;
    logic [CW-1:0]                  b_cnt_reg, b_cnt_next;
    logic [IW-1:0]                  r_reg, r_next;
    logic [IW-1:0]                  c_reg, c_next;
    logic [IW-1:0]                  k_reg, k_next;

    logic                           cfg_wr;
    logic                           in_acc;
    logic                           a_we, b_we;
    logic                           run_done;
    logic                           k_end, c_end, r_end;
    logic                           out_free;
    logic                           emit_elem;
    logic                           emit_err;

    logic [mm_pkg::NEED_W-1:0]      a_idx, b_idx;
    logic [AW-1:0]                  a_raddr, b_raddr;
    logic [mm_pkg::ELEM_W-1:0]      a_rdata, b_rdata;

    mm_pkg::mac_ctl_t               iss_ctl_reg, iss_ctl_next;
    mm_pkg::mac_res_t               mac_res;

    logic                           m_tvalid_reg;
    logic [mm_pkg::OUT_W-1:0]       m_tdata_reg;
    logic                           m_tlast_reg;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_first_reg  <= mm_pkg::DIM_W'(8);
            cols_first_reg  <= mm_pkg::DIM_W'(8);
            rows_second_reg <= mm_pkg::DIM_W'(8);
            cols_second_reg <= mm_pkg::DIM_W'(8);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                mm_pkg::REG_ROWS_FIRST:  rows_first_reg  <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_COLS_FIRST:  cols_first_reg  <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_ROWS_SECOND: rows_second_reg <= pwdata[mm_pkg::DIM_W-1:0];
                mm_pkg::REG_COLS_SECOND: cols_second_reg <= pwdata[mm_pkg::DIM_W-1:0];
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mm_pkg::REG_ROWS_FIRST:  prdata = mm_pkg::DATA_W'(rows_first_reg);
            mm_pkg::REG_COLS_FIRST:  prdata = mm_pkg::DATA_W'(cols_first_reg);
            mm_pkg::REG_ROWS_SECOND: prdata = mm_pkg::DATA_W'(rows_second_reg);
            mm_pkg::REG_COLS_SECOND: prdata = mm_pkg::DATA_W'(cols_second_reg);
            default:                 prdata = '0;
        endcase
    end

    // Effective dimensions and store sizes
    assign ra     = mm_pkg::eff_dim(rows_first_reg,  mm_pkg::DIM_W'(MAX_DIM));
    assign ca     = mm_pkg::eff_dim(cols_first_reg,  mm_pkg::DIM_W'(MAX_DIM));
    assign rb     = mm_pkg::eff_dim(rows_second_reg, mm_pkg::DIM_W'(MAX_DIM));
    assign cb     = mm_pkg::eff_dim(cols_second_reg, mm_pkg::DIM_W'(MAX_DIM));
    assign need_a = mm_pkg::NEED_W'(ra) * mm_pkg::NEED_W'(ca);
    assign need_b = mm_pkg::NEED_W'(rb) * mm_pkg::NEED_W'(cb);

    // Load: write into the store named by kind unless it is full
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign a_we     = in_acc & ~s_tuser & (mm_pkg::NEED_W'(a_cnt_reg) < need_a);
    assign b_we     = in_acc &  s_tuser & (mm_pkg::NEED_W'(b_cnt_reg) < need_b);
    assign run_done = in_acc
                    & (mm_pkg::NEED_W'(a_cnt_reg + CW'(a_we)) >= need_a)
                    & (mm_pkg::NEED_W'(b_cnt_reg + CW'(b_we)) >= need_b);

    // Store read addresses for the current term
    assign a_idx   = mm_pkg::NEED_W'(r_reg) * mm_pkg::NEED_W'(ca) + mm_pkg::NEED_W'(k_reg);
    assign b_idx   = mm_pkg::NEED_W'(k_reg) * mm_pkg::NEED_W'(cb) + mm_pkg::NEED_W'(c_reg);
    assign a_raddr = a_idx[AW-1:0];
    assign b_raddr = b_idx[AW-1:0];

    mm_ram #(
        .WIDTH (mm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_first_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mm_ram #(
        .WIDTH (mm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_second_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_cnt_reg[AW-1:0]),
        .wdata (s_tdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mm_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (iss_ctl_reg),
        .a     (a_rdata),
        .b     (b_rdata),
        .res   (mac_res)
    );

    // Loop bounds
    assign k_end    = (mm_pkg::DIM_W'(k_reg) + mm_pkg::DIM_W'(1)) == ca;
    assign c_end    = (mm_pkg::DIM_W'(c_reg) + mm_pkg::DIM_W'(1)) == cb;
    assign r_end    = (mm_pkg::DIM_W'(r_reg) + mm_pkg::DIM_W'(1)) == ra;
    assign out_free = ~m_tvalid_reg | m_tready;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        a_cnt_next   = a_cnt_reg + CW'(a_we);
        b_cnt_next   = b_cnt_reg + CW'(b_we);
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        iss_ctl_next = '0;
        emit_elem    = 1'b0;
        emit_err     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                r_next = '0;
                c_next = '0;
                k_next = '0;
                if (run_done)
                begin
                    a_cnt_next = '0;
                    b_cnt_next = '0;
                    state_next = (ca != rb) ? ST_ERR : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                iss_ctl_next.valid = 1'b1;
                iss_ctl_next.last  = k_end;
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (mac_res.done)
                begin
                    if (out_free)
                        emit_elem = 1'b1;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                emit_elem = out_free;
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    emit_err   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance to the next product element after it is handed over
        if (emit_elem)
        begin
            if (c_end)
            begin
                c_next     = '0;
                r_next     = r_reg + IW'(1);
                state_next = r_end ? ST_IDLE : ST_ISSUE;
            end
            else
            begin
                c_next     = c_reg + IW'(1);
                state_next = ST_ISSUE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            a_cnt_reg   <= '0;
            b_cnt_reg   <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            k_reg       <= '0;
            iss_ctl_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            a_cnt_reg   <= a_cnt_next;
            b_cnt_reg   <= b_cnt_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            k_reg       <= k_next;
            iss_ctl_reg <= iss_ctl_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit_elem | emit_err)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_err)
        begin
            m_tdata_reg <= {mm_pkg::STATUS_MISMATCH, {(2 * mm_pkg::IDX_W){1'b0}},
                            {mm_pkg::ELEM_W{1'b0}}};
            m_tlast_reg <= 1'b1;
        end
        else if (emit_elem)
        begin
            m_tdata_reg <= {mac_res.sat ? mm_pkg::STATUS_SAT : mm_pkg::STATUS_OK,
                            mm_pkg::IDX_W'(c_reg), mm_pkg::IDX_W'(r_reg), mac_res.value};
            m_tlast_reg <= r_end & c_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_DIM = 8;

    // Element kinds carried in tuser
    localparam logic KIND_FIRST  = 1'b0;
    localparam logic KIND_SECOND = 1'b1;

    // One product element as it leaves the block
    typedef struct packed {
        logic [mm_pkg::ELEM_W-1:0] product;
        logic [mm_pkg::IDX_W-1:0]  row_idx;
        logic [mm_pkg::IDX_W-1:0]  col_idx;
        logic [mm_pkg::STAT_W-1:0] status;
        logic                      last;
    } product_item_t;

    // One row of the directed plan: a register write or an element
    typedef struct packed {
        bit                        is_reg;
        logic [1:0]                idx;
        logic [mm_pkg::DIM_W-1:0]  value;
        logic                      kind;
        logic [mm_pkg::ELEM_W-1:0] elem;
        bit                        pinned;
        logic [mm_pkg::ELEM_W-1:0] pin_product;
        logic [mm_pkg::STAT_W-1:0] pin_status;
    } plan_row_t;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [mm_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [mm_pkg::DATA_W-1:0]   pwdata   = '0;
    logic [mm_pkg::DATA_W-1:0]   prdata;
    logic                        pready;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [mm_pkg::ELEM_W-1:0]   s_tdata  = '0;   // [31:0] element
    logic                        s_tuser  = 1'b0; // [0] kind
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [mm_pkg::OUT_W-1:0]    m_tdata;         // [31:0] product, [34:32] row_index,
                                                  // [37:35] col_index, [39:38] status
    logic                        m_tlast;

    // Shadow of the dimension registers and of the two element stores
    logic [mm_pkg::DIM_W-1:0]    dims [4];
    logic signed [31:0]          first_mat [64];
    logic signed [31:0]          second_mat [64];
    int                          first_fill;
    int                          second_fill;

    product_item_t               pending_products [$];
    plan_row_t                   plan [$];
    bit                          idling = 1'b1;

    int errors       = 0;
    int items_in     = 0;
    int results_seen = 0;
    int pairs_done   = 0;
    int mismatches   = 0;
    int saturated    = 0;

    matrix_multiply #(
        .MAX_DIM (MAX_DIM)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // Give up on a hung run
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int eff_dim_of(logic [mm_pkg::DIM_W-1:0] code);
        if (code == 0)
            return 1;
        if (code > MAX_DIM)
            return MAX_DIM;
        return int'(code);
    endfunction

    // Store one element; once both matrices are complete queue the product elements
    function automatic bit load_and_multiply(logic kind, logic [mm_pkg::ELEM_W-1:0] elem);
        int                 ra;
        int                 ca;
        int                 rb;
        int                 cb;
        bit                 kept;
        logic signed [71:0] acc;
        logic signed [71:0] rounded;
        product_item_t      res;
        ra   = eff_dim_of(dims[mm_pkg::REG_ROWS_FIRST]);
        ca   = eff_dim_of(dims[mm_pkg::REG_COLS_FIRST]);
        rb   = eff_dim_of(dims[mm_pkg::REG_ROWS_SECOND]);
        cb   = eff_dim_of(dims[mm_pkg::REG_COLS_SECOND]);
        kept = 1'b0;
        if (kind == KIND_FIRST)
        begin
            if (first_fill < ra * ca)
            begin
                first_mat[first_fill] = elem;
                first_fill++;
                kept = 1'b1;
            end
        end
        else if (second_fill < rb * cb)
        begin
            second_mat[second_fill] = elem;
            second_fill++;
            kept = 1'b1;
        end
        if (first_fill < ra * ca || second_fill < rb * cb)
            return kept;

        first_fill  = 0;
        second_fill = 0;
        pairs_done++;
        if (ca != rb)
        begin
            res = '{32'd0, 3'd0, 3'd0, mm_pkg::STATUS_MISMATCH, 1'b1};
            pending_products.push_back(res);
            mismatches++;
            return kept;
        end

        // Exact Q40.32 sum, round half up, then clamp to 32 bits
        for (int r = 0; r < ra; r++)
        begin
            for (int c = 0; c < cb; c++)
            begin
                acc = '0;
                for (int k = 0; k < ca; k++)
                    acc = acc + 72'(first_mat[r * ca + k]) * 72'(second_mat[k * cb + c]);
                rounded     = (acc + 72'sd32768) >>> mm_pkg::FRAC_W;
                res.row_idx = 3'(r);
                res.col_idx = 3'(c);
                res.last    = (r == ra - 1) && (c == cb - 1);
                if (rounded > 72'sd2147483647)
                begin
                    res.product = 32'h7FFF_FFFF;
                    res.status  = mm_pkg::STATUS_SAT;
                    saturated++;
                end
                else if (rounded < -72'sd2147483648)
                begin
                    res.product = 32'h8000_0000;
                    res.status  = mm_pkg::STATUS_SAT;
                    saturated++;
                end
                else
                begin
                    res.product = rounded[31:0];
                    res.status  = mm_pkg::STATUS_OK;
                end
                pending_products.push_back(res);
            end
        end
        return kept;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    function automatic void plan_reg(logic [1:0] idx, logic [mm_pkg::DIM_W-1:0] value);
        plan_row_t row;
        row        = '0;
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(logic kind, logic [mm_pkg::ELEM_W-1:0] elem,
                                      bit pinned = 1'b0,
                                      logic [mm_pkg::ELEM_W-1:0] product = '0,
                                      logic [mm_pkg::STAT_W-1:0] status = mm_pkg::STATUS_OK);
        plan_row_t row;
        row             = '0;
        row.kind        = kind;
        row.elem        = elem;
        row.pinned      = pinned;
        row.pin_product = product;
        row.pin_status  = status;
        plan.push_back(row);
    endfunction

    function automatic logic [mm_pkg::ELEM_W-1:0] pick_elem();
        int v;
        case ($urandom_range(9))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2, 3, 4: v = $urandom();
            default: v = int'($urandom_range(524288)) - 262144;
        endcase
        return v;
    endfunction

    // Mostly small sizes, now and then up to the largest
    function automatic int pick_dim();
        if ($urandom_range(9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(4, MAX_DIM);
    endfunction

    // Register code for a size, using out-of-range codes where they map to it
    function automatic logic [mm_pkg::DIM_W-1:0] dim_code(int d);
        if (d == 1 && $urandom_range(2) == 0)
            return '0;
        if (d == MAX_DIM && $urandom_range(1) == 0)
            return 4'($urandom_range(MAX_DIM + 1, 15));
        return 4'(d);
    endfunction

    // Write one register: setup cycle, access cycle, then release the bus
    task automatic reg_write(logic [1:0] idx, logic [mm_pkg::DIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        dims[idx]  = value;
        @(posedge clk);
    endtask

    // Drop valid, drain every pending product element, let the block go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Offer one element, hold it until taken, then predict its effect
    task automatic send_elem(input logic kind, input logic [mm_pkg::ELEM_W-1:0] elem,
                             input bit pinned,
                             input logic [mm_pkg::ELEM_W-1:0] pin_product,
                             input logic [mm_pkg::STAT_W-1:0] pin_status, output bit kept);
        product_item_t pin_res;
        while (idling && $urandom_range(99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= elem;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_in++;
        kept = load_and_multiply(kind, elem);
        // A pinned row replaces the single predicted element with a typed one
        if (pinned)
        begin
            pin_res.product = pin_product;
            pin_res.row_idx = 3'd0;
            pin_res.col_idx = 3'd0;
            pin_res.status  = pin_status;
            pin_res.last    = 1'b1;
            void'(pending_products.pop_back());
            pending_products.push_back(pin_res);
        end
    endtask

    // Stall the result side at random while idling is set
    always @(posedge clk)
        m_tready <= !idling || ($urandom_range(99) >= 33);

    // Compare each taken product element with the oldest prediction
    always @(posedge clk)
    begin : result_check
        product_item_t got;
        product_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.product = m_tdata[31:0];
            got.row_idx = m_tdata[34:32];
            got.col_idx = m_tdata[37:35];
            got.status  = m_tdata[39:38];
            got.last    = m_tlast;
            results_seen++;
            if (pending_products.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got %0h last %0b",
                         $time, m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                want = pending_products.pop_front();
                check_field("product", want.product, got.product);
                check_field("row_index", 32'(want.row_idx), 32'(got.row_idx));
                check_field("col_index", 32'(want.col_idx), 32'(got.col_idx));
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("last", 32'(want.last), 32'(got.last));
            end
        end
    end

    initial
    begin
        plan_row_t                row;
        bit                       kept;
        int                       kept_random;
        int                       phase;
        int                       start_pairs;
        int                       dc;
        logic                     kind;
        logic [mm_pkg::DIM_W-1:0] raw_dims [4];

        dims[mm_pkg::REG_ROWS_FIRST]  = 4'd8;
        dims[mm_pkg::REG_COLS_FIRST]  = 4'd8;
        dims[mm_pkg::REG_ROWS_SECOND] = 4'd8;
        dims[mm_pkg::REG_COLS_SECOND] = 4'd8;
        first_fill                    = 0;
        second_fill                   = 0;

        // Scalar products at the edges of the range, codes of zero for size one
        plan_reg(mm_pkg::REG_ROWS_FIRST, 4'd0);
        plan_reg(mm_pkg::REG_COLS_FIRST, 4'd1);
        plan_reg(mm_pkg::REG_ROWS_SECOND, 4'd1);
        plan_reg(mm_pkg::REG_COLS_SECOND, 4'd0);
        plan_item(KIND_FIRST, 32'h0001_0000);
        plan_item(KIND_SECOND, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, mm_pkg::STATUS_OK);
        plan_item(KIND_FIRST, 32'h8000_0000);
        plan_item(KIND_SECOND, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, mm_pkg::STATUS_SAT);
        plan_item(KIND_SECOND, 32'h7FFF_FFFF);
        plan_item(KIND_FIRST, 32'h8000_0000, 1'b1, 32'h8000_0000, mm_pkg::STATUS_SAT);
        plan_item(KIND_FIRST, 32'h7FFF_FFFF);
        plan_item(KIND_SECOND, 32'hFFFF_0000, 1'b1, 32'h8000_0001, mm_pkg::STATUS_OK);
        // Half an LSB rounds up on both signs
        plan_item(KIND_FIRST, 32'h0000_0001);
        plan_item(KIND_SECOND, 32'h0000_8000, 1'b1, 32'h0000_0001, mm_pkg::STATUS_OK);
        plan_item(KIND_SECOND, 32'h0000_8000);
        plan_item(KIND_FIRST, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mm_pkg::STATUS_OK);
        // Inner sizes differ; the third first-matrix element finds its store full
        plan_reg(mm_pkg::REG_COLS_FIRST, 4'd2);
        plan_item(KIND_FIRST, 32'h1234_5678);
        plan_item(KIND_FIRST, 32'hEDCB_A987);
        plan_item(KIND_FIRST, 32'hFFFF_FFFF);
        plan_item(KIND_SECOND, 32'h0001_0000, 1'b1, 32'h0000_0000, mm_pkg::STATUS_MISMATCH);
        // Shrink the first matrix after three of its four elements are loaded
        plan_reg(mm_pkg::REG_ROWS_FIRST, 4'd2);
        plan_reg(mm_pkg::REG_ROWS_SECOND, 4'd2);
        plan_item(KIND_FIRST, 32'h0002_0000);
        plan_item(KIND_FIRST, 32'h0003_0000);
        plan_item(KIND_FIRST, 32'hFFFF_8000);
        plan_reg(mm_pkg::REG_ROWS_FIRST, 4'd1);
        plan_item(KIND_FIRST, 32'h5555_5555);
        plan_item(KIND_SECOND, 32'h0001_0000);
        plan_item(KIND_SECOND, 32'h0000_8000);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_reg)
            begin
                settle();
                reg_write(row.idx, row.value);
            end
            else
                send_elem(row.kind, row.elem, row.pinned, row.pin_product, row.pin_status, kept);
        end

        // Random matrix pairs, first the widest output shape, then the longest inner size
        kept_random = 0;
        phase       = 0;
        while (kept_random < 70)
        begin
            idling = !(kept_random >= 25 && kept_random < 55);
            if (phase < 2 || $urandom_range(9) < 7)
            begin
                if (phase == 0)
                begin
                    raw_dims[mm_pkg::REG_ROWS_FIRST]  = 4'd15;
                    raw_dims[mm_pkg::REG_COLS_FIRST]  = 4'd0;
                    raw_dims[mm_pkg::REG_ROWS_SECOND] = 4'd0;
                    raw_dims[mm_pkg::REG_COLS_SECOND] = 4'd15;
                end
                else if (phase == 1)
                begin
                    raw_dims[mm_pkg::REG_ROWS_FIRST]  = 4'd0;
                    raw_dims[mm_pkg::REG_COLS_FIRST]  = 4'd8;
                    raw_dims[mm_pkg::REG_ROWS_SECOND] = 4'd15;
                    raw_dims[mm_pkg::REG_COLS_SECOND] = 4'd0;
                end
                else
                begin
                    dc                                = pick_dim();
                    raw_dims[mm_pkg::REG_ROWS_FIRST]  = dim_code(pick_dim());
                    raw_dims[mm_pkg::REG_COLS_FIRST]  = dim_code(dc);
                    raw_dims[mm_pkg::REG_ROWS_SECOND] = ($urandom_range(9) == 0) ?
                                                        dim_code(pick_dim()) : dim_code(dc);
                    raw_dims[mm_pkg::REG_COLS_SECOND] = dim_code(pick_dim());
                end
                settle();
                reg_write(mm_pkg::REG_ROWS_FIRST, raw_dims[mm_pkg::REG_ROWS_FIRST]);
                reg_write(mm_pkg::REG_COLS_FIRST, raw_dims[mm_pkg::REG_COLS_FIRST]);
                reg_write(mm_pkg::REG_ROWS_SECOND, raw_dims[mm_pkg::REG_ROWS_SECOND]);
                reg_write(mm_pkg::REG_COLS_SECOND, raw_dims[mm_pkg::REG_COLS_SECOND]);
            end

            // Interleave both matrices until the pair completes, with a few extras
            start_pairs = pairs_done;
            while (pairs_done == start_pairs)
            begin
                if (first_fill >= eff_dim_of(dims[mm_pkg::REG_ROWS_FIRST]) *
                                  eff_dim_of(dims[mm_pkg::REG_COLS_FIRST]))
                    kind = ($urandom_range(7) == 0) ? KIND_FIRST : KIND_SECOND;
                else if (second_fill >= eff_dim_of(dims[mm_pkg::REG_ROWS_SECOND]) *
                                        eff_dim_of(dims[mm_pkg::REG_COLS_SECOND]))
                    kind = ($urandom_range(7) == 0) ? KIND_SECOND : KIND_FIRST;
                else
                    kind = ($urandom_range(1) == 0) ? KIND_FIRST : KIND_SECOND;
                send_elem(kind, pick_elem(), 1'b0, '0, mm_pkg::STATUS_OK, kept);
                kept_random += kept;
            end
            phase++;
        end

        settle();
        $display("Sent %0d elements forming %0d matrix pairs, %0d of them with unequal inner sizes.",
                 items_in, pairs_done, mismatches);
        $display("Received %0d product elements, %0d saturated; %0d errors.",
                 results_seen, saturated, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
